FILE: rtl/mst_pkg.sv
// Shared types and constants of the steering controller.
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;

    localparam int N_IN        = 9;
    localparam int N_HIDDEN    = 4;
    localparam int N_OUT       = 2;
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_BITS    = $clog2(SIG_ENTRIES);

    localparam int N_STORE  = N_HIDDEN * (N_IN + 1) + N_OUT * (N_HIDDEN + 1);
    localparam int OUT_BASE = N_HIDDEN * (N_IN + 1);
    localparam int ADDR_W   = $clog2(N_STORE);

    localparam int MAX_TERMS = (N_IN + 1 > N_HIDDEN + 1) ? (N_IN + 1) : (N_HIDDEN + 1);
    localparam int J_W       = $clog2(MAX_TERMS);
    localparam int H_W       = (N_HIDDEN > 2) ? $clog2(N_HIDDEN) : 1;

    localparam int ACC_W  = 38;
    localparam int HID_FB = 20;
    localparam int OUT_FB = 28;

    localparam int HEAD_FULL = 92160;

    // Input kinds carried on tuser.
    localparam logic [1:0] KIND_STEP    = 2'd0;
    localparam logic [1:0] KIND_LOAD    = 2'd1;
    localparam logic [1:0] KIND_HEADING = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TURN_SPEED = 1'b0;
    localparam logic CFG_MAX_SPEED  = 1'b1;

    localparam logic [14:0] TURN_SPEED_RST = 15'd11520;
    localparam logic [15:0] MAX_SPEED_RST  = 16'd128;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_H_MAC,
        ST_H_DRAIN,
        ST_H_SIG,
        ST_O_MAC,
        ST_O_DRAIN,
        ST_O_SIG,
        ST_UPD1,
        ST_UPD2,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              load_apply;
        logic              rd_en;
        logic              layer;
        logic [ADDR_W-1:0] rd_addr;
        logic [J_W-1:0]    sel;
        logic              acc_clr;
        logic              sig_store;
        logic [H_W-1:0]    sig_idx;
        logic              upd1;
        logic              upd2;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       out_valid;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/mlp_steering_controller.sv
// Top level of the 9-4-2 sigmoid perceptron steering controller.
//
// Requests arrive on the s_ channel. tuser carries the kind: sensor step,
// weight load or heading set. A sensor step runs the nine readings through
// four hidden neurons and two output neurons on one shared multiply-
// accumulate unit fed by a 50-entry weight RAM, then turns the heading and
// sets the speed. Loads write one weight or the heading; a fourth kind writes nothing.
// Every request gives exactly one result on the m_ channel.
// A sensor step reads the weight RAM once per weight, each neuron then
// drains the multiply-accumulate and stores its sigmoid, then two update
// steps turn the heading and set the speed, and the output register is
// loaded. A load is applied and its result goes to the output register.
// One request is worked on at a time; s_tready is high only while the
// block waits for a request.
// The result waits in an output register; while m_tready is low the
// finished result holds and the next result waits in the block.
// Reset clears heading, speed and step count and sets turn_speed and
// max_speed to their defaults. The weight RAM is not cleared and must be
// loaded before sensor steps. cfg_we writes the register that cfg_index selects.
`timescale 1ns / 1ps
`default_nettype none
module mlp_steering_controller (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // food_left, food_ahead, food_right, wall_ahead, wall_left, wall_right,
    // robot_left, robot_ahead, robot_right, load_index, load_value
    input  wire logic [167:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // heading, speed_out, turn_activation, drive_activation, step_count, zero pad
    output logic [103:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [15:0]  cfg_data
);

    mst_pkg::cmd_t    cmd;
    mst_pkg::status_t status;
    logic [16:0]      heading;
    logic [15:0]      speed_out;
    logic [15:0]      turn_activation;
    logic [15:0]      drive_activation;
    logic [31:0]      step_count;

    mst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .s_kind   (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mst_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_kind       (s_tuser),
        .in_sensors    (s_tdata[143:0]),
        .in_load_index (s_tdata[149:144]),
        .in_load_value (s_tdata[167:150]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .out_heading   (heading),
        .out_speed     (speed_out),
        .out_turn_act  (turn_activation),
        .out_drive_act (drive_activation),
        .out_step      (step_count)
    );

    assign m_tdata = {7'd0, step_count, drive_activation, turn_activation, speed_out, heading};

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a request is in progress");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:0] <= 17'd92160)
        else $error("heading outside 0..360 degrees");

    a_load_zero_act: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) && status.kind != mst_pkg::KIND_STEP |-> m_tdata[64:33] == 32'd0)
        else $error("activations not zero for a load result");

endmodule
`default_nettype wire

FILE: rtl/mst_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/mst_ctrl.sv
// Sequencing state machine for the perceptron passes and state updates.
`timescale 1ns / 1ps
`default_nettype none
module mst_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    input  wire logic            m_tready,
    input  wire logic [1:0]      s_kind,
    input  wire mst_pkg::status_t status,
    output logic                 s_tready,
    output mst_pkg::cmd_t        cmd
);

    mst_pkg::state_t           state_reg, state_next;
    logic [mst_pkg::J_W-1:0]   j_reg, j_next;
    logic [mst_pkg::H_W-1:0]   h_reg, h_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mst_pkg::ST_IDLE;
            j_reg     <= '0;
            h_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            h_reg     <= h_next;
        end
    end

    // Next state and loop counters.
    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        h_next     = h_reg;
        case (state_reg)
            mst_pkg::ST_IDLE:
            begin
                j_next = '0;
                h_next = '0;
                if (s_tvalid)
                    state_next = (s_kind == mst_pkg::KIND_STEP) ? mst_pkg::ST_H_MAC
                                                                 : mst_pkg::ST_LOAD;
            end
            mst_pkg::ST_LOAD:
                state_next = mst_pkg::ST_FIN;
            mst_pkg::ST_H_MAC:
            begin
                if (j_reg == mst_pkg::J_W'(mst_pkg::N_IN))
                begin
                    j_next     = '0;
                    state_next = mst_pkg::ST_H_DRAIN;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            mst_pkg::ST_H_DRAIN:
                state_next = mst_pkg::ST_H_SIG;
            mst_pkg::ST_H_SIG:
            begin
                if (h_reg == mst_pkg::H_W'(mst_pkg::N_HIDDEN - 1))
                begin
                    h_next     = '0;
                    state_next = mst_pkg::ST_O_MAC;
                end
                else
                begin
                    h_next     = h_reg + 1'b1;
                    state_next = mst_pkg::ST_H_MAC;
                end
            end
            mst_pkg::ST_O_MAC:
            begin
                if (j_reg == mst_pkg::J_W'(mst_pkg::N_HIDDEN))
                begin
                    j_next     = '0;
                    state_next = mst_pkg::ST_O_DRAIN;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            mst_pkg::ST_O_DRAIN:
                state_next = mst_pkg::ST_O_SIG;
            mst_pkg::ST_O_SIG:
            begin
                if (h_reg == mst_pkg::H_W'(mst_pkg::N_OUT - 1))
                begin
                    h_next     = '0;
                    state_next = mst_pkg::ST_UPD1;
                end
                else
                begin
                    h_next     = h_reg + 1'b1;
                    state_next = mst_pkg::ST_O_MAC;
                end
            end
            mst_pkg::ST_UPD1:
                state_next = mst_pkg::ST_UPD2;
            mst_pkg::ST_UPD2:
                state_next = mst_pkg::ST_FIN;
            mst_pkg::ST_FIN:
            begin
                if (!status.out_valid || m_tready)
                    state_next = mst_pkg::ST_IDLE;
            end
            default:
                state_next = mst_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd         = '0;
        cmd.sel     = j_reg;
        cmd.sig_idx = h_reg;
        s_tready    = 1'b0;
        case (state_reg)
            mst_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                cmd.acc_clr = 1'b1;
            end
            mst_pkg::ST_LOAD:
                cmd.load_apply = 1'b1;
            mst_pkg::ST_H_MAC:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = mst_pkg::ADDR_W'(h_reg) * mst_pkg::ADDR_W'(mst_pkg::N_IN + 1)
                              + mst_pkg::ADDR_W'(j_reg);
            end
            mst_pkg::ST_H_SIG:
            begin
                cmd.sig_store = 1'b1;
                cmd.acc_clr   = 1'b1;
            end
            mst_pkg::ST_O_MAC:
            begin
                cmd.rd_en   = 1'b1;
                cmd.layer   = 1'b1;
                cmd.rd_addr = mst_pkg::ADDR_W'(mst_pkg::OUT_BASE)
                              + mst_pkg::ADDR_W'(h_reg)
                                * mst_pkg::ADDR_W'(mst_pkg::N_HIDDEN + 1)
                              + mst_pkg::ADDR_W'(j_reg);
            end
            mst_pkg::ST_O_DRAIN:
                cmd.layer = 1'b1;
            mst_pkg::ST_O_SIG:
            begin
                cmd.layer     = 1'b1;
                cmd.sig_store = 1'b1;
                cmd.acc_clr   = 1'b1;
            end
            mst_pkg::ST_UPD1:
                cmd.upd1 = 1'b1;
            mst_pkg::ST_UPD2:
                cmd.upd2 = 1'b1;
            mst_pkg::ST_FIN:
                cmd.out_load = !status.out_valid || m_tready;
            default:
                cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/mst_dp.sv
// Datapath: weight RAM, shared multiply-accumulate, sigmoid lookup and state.
`timescale 1ns / 1ps
`default_nettype none
module mst_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mst_pkg::cmd_t       cmd,
    output mst_pkg::status_t         status,
    input  wire logic [1:0]          in_kind,
    input  wire logic [16*mst_pkg::N_IN-1:0] in_sensors,
    input  wire logic [5:0]          in_load_index,
    input  wire logic signed [17:0]  in_load_value,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                m_tready,
    output logic                     out_valid,
    output logic [16:0]              out_heading,
    output logic [15:0]              out_speed,
    output logic [15:0]              out_turn_act,
    output logic [15:0]              out_drive_act,
    output logic [31:0]              out_step
);

    logic [1:0]               kind_reg;
    logic signed [15:0]       x_reg [mst_pkg::N_IN];
    logic [5:0]               lidx_reg;
    logic signed [17:0]       lval_reg;

    logic [14:0]              turn_speed_reg;
    logic [15:0]              max_speed_reg;

    logic [16:0]              heading_reg;
    logic [15:0]              speed_reg;
    logic [31:0]              step_reg;

    logic signed [mst_pkg::ACC_W-1:0] acc_reg;
    logic                     mac_vld_reg;
    logic                     mac_layer_reg;
    logic [mst_pkg::J_W-1:0]  mac_sel_reg;
    logic [15:0]              act_reg [mst_pkg::N_HIDDEN];
    logic [15:0]              o0_reg, o1_reg;

    logic signed [33:0]       p_reg;
    logic [31:0]              sprod_reg;

    logic                     out_valid_reg;
    logic [16:0]              oh_reg;
    logic [15:0]              os_reg, ot_reg, od_reg;
    logic [31:0]              oc_reg;

    logic [15:0]              w_rd;
    logic                     ram_we;
    logic signed [15:0]       w_sat;
    logic signed [16:0]       hid_ops [mst_pkg::MAX_TERMS];
    logic signed [16:0]       out_ops [mst_pkg::MAX_TERMS];
    logic signed [16:0]       op_a;
    logic signed [32:0]       prod;
    logic [15:0]              sig_val;
    wire logic [15:0]         sig_rom [mst_pkg::SIG_ENTRIES];

    logic [33:0]              abs_p;
    logic [18:0]              mag;
    logic signed [18:0]       head_sum;
    logic [16:0]              head_wrapped;
    logic signed [18:0]       set_wrap;
    logic [16:0]              set_head;
    logic [32:0]              spd_round;

    always_comb
    begin
        status.kind      = kind_reg;
        status.out_valid = out_valid_reg;
    end

    // Weight load saturates to Q4.12.
    always_comb
    begin
        if (lval_reg > 18'sd32767)
            w_sat = 16'sh7FFF;
        else if (lval_reg < -18'sd32768)
            w_sat = 16'sh8000;
        else
            w_sat = lval_reg[15:0];
    end

    assign ram_we = cmd.load_apply && (kind_reg == mst_pkg::KIND_LOAD)
                    && (lidx_reg < 6'(mst_pkg::N_STORE));

    mst_ram #(
        .WIDTH (16),
        .DEPTH (mst_pkg::N_STORE)
    ) u_wram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (lidx_reg[mst_pkg::ADDR_W-1:0]),
        .wdata (w_sat),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (w_rd)
    );

    // Operand tables: slot 0 is the -1 bias of each layer.
    always_comb
    begin
        for (int i = 0; i < mst_pkg::MAX_TERMS; i++)
        begin
            hid_ops[i] = '0;
            out_ops[i] = '0;
        end
        hid_ops[0] = -17'sd256;
        out_ops[0] = -17'sd65536;
        for (int i = 0; i < mst_pkg::N_IN; i++)
            hid_ops[i + 1] = 17'(x_reg[i]);
        for (int i = 0; i < mst_pkg::N_HIDDEN; i++)
            out_ops[i + 1] = $signed({1'b0, act_reg[i]});
    end

    assign op_a = mac_layer_reg ? out_ops[mac_sel_reg] : hid_ops[mac_sel_reg];
    assign prod = op_a * $signed(w_rd);

    // Sigmoid table built at elaboration: exp(-|m|) as a Taylor series of
    // exp(-|m|/16) in Q31, squared four times, then 1/(1+e), or e/(1+e) for negative m, in Q0.16.
    for (genvar k = 0; k < mst_pkg::SIG_ENTRIES; k++)
    begin : g_sig
        localparam longint          XQ  = ((longint'(2 * k + 1) * 524288)
                                           / mst_pkg::SIG_ENTRIES) - 524288;
        localparam longint unsigned ONE = 64'd1 << 31;
        localparam longint unsigned Y   = unsigned'((XQ < 0) ? -XQ : XQ) << 11;
        localparam longint unsigned T1  = (ONE * Y) >> 31;
        localparam longint unsigned T2  = ((T1 * Y) >> 31) / 2;
        localparam longint unsigned T3  = ((T2 * Y) >> 31) / 3;
        localparam longint unsigned T4  = ((T3 * Y) >> 31) / 4;
        localparam longint unsigned T5  = ((T4 * Y) >> 31) / 5;
        localparam longint unsigned T6  = ((T5 * Y) >> 31) / 6;
        localparam longint unsigned T7  = ((T6 * Y) >> 31) / 7;
        localparam longint unsigned T8  = ((T7 * Y) >> 31) / 8;
        localparam longint unsigned T9  = ((T8 * Y) >> 31) / 9;
        localparam longint unsigned T10 = ((T9 * Y) >> 31) / 10;
        localparam longint unsigned T11 = ((T10 * Y) >> 31) / 11;
        localparam longint unsigned T12 = ((T11 * Y) >> 31) / 12;
        localparam longint unsigned T13 = ((T12 * Y) >> 31) / 13;
        localparam longint unsigned T14 = ((T13 * Y) >> 31) / 14;
        localparam longint unsigned E0  = ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7
                                          + T8 - T9 + T10 - T11 + T12 - T13 + T14;
        localparam longint unsigned E1  = (E0 * E0) >> 31;
        localparam longint unsigned E2  = (E1 * E1) >> 31;
        localparam longint unsigned E3  = (E2 * E2) >> 31;
        localparam longint unsigned E4  = (E3 * E3) >> 31;
        localparam longint unsigned NUM = (XQ < 0) ? E4 : ONE;
        localparam longint unsigned DEN = ONE + E4;
        localparam longint unsigned R   = (NUM * 65536 + DEN / 2) / DEN;
        assign sig_rom[k] = (R > 65535) ? 16'hFFFF : 16'(R);
    end

    function automatic logic [mst_pkg::SIG_BITS-1:0] sig_index(
        input logic signed [mst_pkg::ACC_W-1:0] acc,
        input logic                             out_layer);
        logic signed [mst_pkg::ACC_W:0] diff;
        logic signed [mst_pkg::ACC_W:0] idx;
        if (out_layer)
        begin
            diff = (mst_pkg::ACC_W+1)'(acc) + ((mst_pkg::ACC_W+1)'(1) <<< (mst_pkg::OUT_FB + 3));
            idx  = diff >>> (mst_pkg::OUT_FB + 4 - mst_pkg::SIG_BITS);
        end
        else
        begin
            diff = (mst_pkg::ACC_W+1)'(acc) + ((mst_pkg::ACC_W+1)'(1) <<< (mst_pkg::HID_FB + 3));
            idx  = diff >>> (mst_pkg::HID_FB + 4 - mst_pkg::SIG_BITS);
        end
        if (diff < 0)
            return '0;
        else if (idx >= (mst_pkg::ACC_W+1)'(mst_pkg::SIG_ENTRIES))
            return mst_pkg::SIG_BITS'(mst_pkg::SIG_ENTRIES - 1);
        else
            return idx[mst_pkg::SIG_BITS-1:0];
    endfunction

    assign sig_val = sig_rom[sig_index(acc_reg, cmd.layer)];

    // Heading and speed update arithmetic.
    always_comb
    begin
        abs_p    = p_reg[33] ? 34'(-p_reg) : 34'(p_reg);
        mag      = 19'((abs_p + 34'd16384) >> 15);
        head_sum = $signed({2'b00, heading_reg}) + (p_reg[33] ? -$signed(mag) : $signed(mag));
        if (head_sum < 0)
            head_wrapped = 17'(head_sum + 19'sd92160);
        else if (head_sum > 19'sd92160)
            head_wrapped = 17'(head_sum - 19'sd92160);
        else
            head_wrapped = 17'(head_sum);

        if (lval_reg < 0)
            set_wrap = 19'(lval_reg) + 19'sd92160;
        else if (lval_reg > 18'sd92160)
            set_wrap = 19'(lval_reg) - 19'sd92160;
        else
            set_wrap = 19'(lval_reg);
        if (set_wrap < 0)
            set_head = '0;
        else if (set_wrap > 19'sd92160)
            set_head = 17'(mst_pkg::HEAD_FULL);
        else
            set_head = 17'(set_wrap);

        spd_round = 33'(sprod_reg) + 33'd32768;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_kind;
            for (int i = 0; i < mst_pkg::N_IN; i++)
                x_reg[i] <= in_sensors[16*i +: 16];
            lidx_reg <= in_load_index;
            lval_reg <= in_load_value;
        end
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (mac_vld_reg)
            acc_reg <= acc_reg + mst_pkg::ACC_W'(prod);
        mac_layer_reg <= cmd.layer;
        mac_sel_reg   <= cmd.sel;
        if (cmd.sig_store)
        begin
            if (cmd.layer)
            begin
                if (cmd.sig_idx[0])
                    o1_reg <= sig_val;
                else
                    o0_reg <= sig_val;
            end
            else
                act_reg[cmd.sig_idx] <= sig_val;
        end
        if (cmd.upd1)
        begin
            p_reg     <= ($signed({2'b00, o0_reg}) - 18'sd32768) * $signed({1'b0, turn_speed_reg});
            sprod_reg <= o1_reg * max_speed_reg;
        end
        if (cmd.out_load)
        begin
            oh_reg <= heading_reg;
            os_reg <= speed_reg;
            ot_reg <= (kind_reg == mst_pkg::KIND_STEP) ? o0_reg : 16'd0;
            od_reg <= (kind_reg == mst_pkg::KIND_STEP) ? o1_reg : 16'd0;
            oc_reg <= step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_vld_reg    <= 1'b0;
            heading_reg    <= '0;
            speed_reg      <= '0;
            step_reg       <= '0;
            turn_speed_reg <= mst_pkg::TURN_SPEED_RST;
            max_speed_reg  <= mst_pkg::MAX_SPEED_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mac_vld_reg <= cmd.rd_en;
            if (cfg_we)
            begin
                if (cfg_index == mst_pkg::CFG_TURN_SPEED)
                    turn_speed_reg <= cfg_data[14:0];
                else
                    max_speed_reg <= cfg_data;
            end
            if (cmd.upd2)
            begin
                heading_reg <= head_wrapped;
                speed_reg   <= spd_round[31:16];
                step_reg    <= step_reg + 32'd1;
            end
            else if (cmd.load_apply && kind_reg == mst_pkg::KIND_HEADING)
                heading_reg <= set_head;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_heading   = oh_reg;
    assign out_speed     = os_reg;
    assign out_turn_act  = ot_reg;
    assign out_drive_act = od_reg;
    assign out_step      = oc_reg;

endmodule
`default_nettype wire

FILE: tb/sv/tb_mlp_steering_controller.sv
// Self-checking testbench for the steering controller: directed table plus random requests.
`timescale 1ns / 1ps
module tb_mlp_steering_controller;

    typedef logic signed [15:0] sensors_t [9];

    // Heading sits in the lowest bits, as on m_tdata.
    typedef struct packed {
        logic [31:0] step_count;
        logic [15:0] drive_activation;
        logic [15:0] turn_activation;
        logic [15:0] speed_out;
        logic [16:0] heading;
    } result_t;

    // One directed row: sensors are all sv, or alternate sv and ~sv.
    typedef struct {
        logic [1:0]          kind;
        bit                  alternate;
        logic signed [15:0]  sv;
        logic [5:0]          idx;
        logic signed [17:0]  val;
        bit                  typed;
        logic [16:0]         exp_heading;
    } dir_row_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [167:0]  s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [103:0]  m_tdata;
    logic          cfg_we;
    logic          cfg_index;
    logic [15:0]   cfg_data;

    mlp_steering_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state.
    int unsigned         sig_lut [256];
    logic signed [15:0]  weights [50];
    int                  heading_q;
    int unsigned         speed_q;
    int unsigned         steps_q;
    int unsigned         turn_speed_q;
    int unsigned         max_speed_q;

    result_t     pending_results [$];
    int          errors;
    int unsigned n_steps;
    int unsigned n_loads;
    int unsigned n_results;
    bit          tx_quiet;
    bit          rx_quiet;
    int          rx_stall;
    dir_row_t    dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned sigmoid_entry(input int k);
        longint            xq;
        longint unsigned   one;
        longint unsigned   a;
        longint unsigned   y;
        longint unsigned   sum;
        longint unsigned   term;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   r;
        one  = 64'd1 << 31;
        xq   = ((longint'(2 * k + 1) * 524288) / 256) - 524288;
        a    = (xq < 0) ? -xq : xq;
        y    = a << 11;
        sum  = one;
        term = one;
        for (int n = 1; n <= 14; n++)
        begin
            term = ((term * y) >> 31) / n;
            sum  = (n % 2 == 1) ? sum - term : sum + term;
        end
        for (int s = 0; s < 4; s++)
            sum = (sum * sum) >> 31;
        num = (xq < 0) ? sum : one;
        den = one + sum;
        r   = (num * 65536 + den / 2) / den;
        return (r > 65535) ? 65535 : int'(r);
    endfunction

    function automatic int unsigned activation(input longint acc, input int fb);
        longint lo;
        longint bin;
        lo = -(longint'(8) << fb);
        if (acc < lo)
            return sig_lut[0];
        bin = ((acc - lo) * 256) >>> (fb + 4);
        if (bin > 255)
            bin = 255;
        return sig_lut[bin];
    endfunction

    function automatic int wrap_heading(input longint h);
        if (h < 0)
            h = h + mst_pkg::HEAD_FULL;
        else if (h > mst_pkg::HEAD_FULL)
            h = h - mst_pkg::HEAD_FULL;
        return int'(h);
    endfunction

    // Updates the predicted state for one request and returns its result.
    function automatic result_t steer_predict(input logic [1:0] kind, input sensors_t s,
                                              input logic [5:0] idx,
                                              input logic signed [17:0] val);
        result_t      r;
        longint       x [10];
        longint       acc;
        longint       p;
        longint       mag;
        longint       v;
        int unsigned  act [4];
        int unsigned  o [2];
        int           base;
        o[0] = 0;
        o[1] = 0;
        if (kind == mst_pkg::KIND_STEP)
        begin
            x[0] = -256;
            for (int j = 0; j < 9; j++)
                x[j + 1] = s[j];
            for (int h = 0; h < 4; h++)
            begin
                acc = 0;
                for (int j = 0; j < 10; j++)
                    acc += x[j] * longint'(weights[h * 10 + j]);
                act[h] = activation(acc, 20);
            end
            for (int n = 0; n < 2; n++)
            begin
                base = 40 + n * 5;
                acc  = -65536 * longint'(weights[base]);
                for (int h = 0; h < 4; h++)
                    acc += longint'(act[h]) * longint'(weights[base + 1 + h]);
                o[n] = activation(acc, 28);
            end
            p   = (longint'(o[0]) - 32768) * longint'(turn_speed_q);
            mag = ((p < 0 ? -p : p) + 16384) >>> 15;
            heading_q = wrap_heading(longint'(heading_q) + (p < 0 ? -mag : mag));
            speed_q   = int'((longint'(o[1]) * max_speed_q + 32768) >> 16);
            steps_q   = steps_q + 1;
        end
        else if (kind == mst_pkg::KIND_LOAD)
        begin
            v = val;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            if (idx < 50)
                weights[idx] = v[15:0];
        end
        else if (kind == mst_pkg::KIND_HEADING)
        begin
            v = wrap_heading(longint'(val));
            if (v < 0)
                v = 0;
            if (v > mst_pkg::HEAD_FULL)
                v = mst_pkg::HEAD_FULL;
            heading_q = int'(v);
        end
        r.heading          = heading_q[16:0];
        r.speed_out        = speed_q[15:0];
        r.turn_activation  = o[0][15:0];
        r.drive_activation = o[1][15:0];
        r.step_count       = steps_q;
        return r;
    endfunction

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 70);
    endfunction

    // Drives one request and waits for it to be taken; the result is predicted then.
    task automatic send_request(input logic [1:0] kind, input sensors_t s,
                                input logic [5:0] idx, input logic signed [17:0] val,
                                input bit typed, input logic [16:0] exp_heading);
        logic [167:0] data;
        result_t      r;
        int           gap;
        for (int j = 0; j < 9; j++)
            data[16 * j +: 16] = s[j];
        data[149:144] = idx;
        data[167:150] = val;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = steer_predict(kind, s, idx, val);
        if (typed)
        begin
            r         = '0;
            r.heading = exp_heading;
        end
        pending_results.push_back(r);
        if (kind == mst_pkg::KIND_STEP)
            n_steps++;
        else
            n_loads++;
        gap = tx_quiet ? 0 : gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_results.size() > 0)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            repeat (80) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mst_pkg::CFG_TURN_SPEED)
            turn_speed_q = value & 32'h7FFF;
        else
            max_speed_q = value & 32'hFFFF;
    endtask

    function automatic logic signed [17:0] random_weight();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick < 2)
            return $signed(18'($urandom_range(0, 8191))) - 18'sd4096;
        if (pick == 2)
            return $signed(18'($urandom_range(0, 65535))) - 18'sd32768;
        return $signed(18'($urandom()));
    endfunction

    task automatic random_request();
        sensors_t s;
        int       pick;
        logic [1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            kind = mst_pkg::KIND_STEP;
        else if (pick < 85)
            kind = mst_pkg::KIND_LOAD;
        else if (pick < 94)
            kind = mst_pkg::KIND_HEADING;
        else
            kind = 2'd3;
        for (int j = 0; j < 9; j++)
            s[j] = ($urandom_range(0, 1) == 0) ? 16'($urandom())
                                               : 16'($urandom_range(0, 1023)) - 16'sd512;
        if (kind == mst_pkg::KIND_HEADING && $urandom_range(0, 1) == 0)
            send_request(kind, s, 6'($urandom()),
                         $signed(18'($urandom_range(0, 92160 + 4000))) - 18'sd2000, 0, 0);
        else if (kind == mst_pkg::KIND_HEADING)
            send_request(kind, s, 6'($urandom()), $signed(18'($urandom())), 0, 0);
        else
            send_request(kind, s, 6'($urandom()), random_weight(), 0, 0);
    endtask

    function automatic dir_row_t mk(input logic [1:0] kind, input bit alt,
                                    input logic signed [15:0] sv, input logic [5:0] idx,
                                    input logic signed [17:0] val, input bit typed,
                                    input logic [16:0] eh);
        dir_row_t d;
        d = '{kind, alt, sv, idx, val, typed, eh};
        return d;
    endfunction

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        got = m_tdata[96:0];
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.heading !== want.heading)
                begin
                    $display("%0t: heading exp %0d got %0d", $time, want.heading, got.heading);
                    errors++;
                end
                if (got.speed_out !== want.speed_out)
                begin
                    $display("%0t: speed exp %0d got %0d", $time, want.speed_out,
                             got.speed_out);
                    errors++;
                end
                if (got.turn_activation !== want.turn_activation)
                begin
                    $display("%0t: turn act exp %0d got %0d", $time, want.turn_activation,
                             got.turn_activation);
                    errors++;
                end
                if (got.drive_activation !== want.drive_activation)
                begin
                    $display("%0t: drive act exp %0d got %0d", $time, want.drive_activation,
                             got.drive_activation);
                    errors++;
                end
                if (got.step_count !== want.step_count)
                begin
                    $display("%0t: steps exp %0d got %0d", $time, want.step_count,
                             got.step_count);
                    errors++;
                end
            end
        end
        if (rx_quiet)
            m_tready <= 1'b1;
        else if (rx_stall > 0)
        begin
            rx_stall = rx_stall - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_stall = gap_length();
            m_tready <= (rx_stall == 0);
        end
    end

    initial
    begin
        sensors_t s;
        dir_row_t d;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = mst_pkg::CFG_TURN_SPEED;
        cfg_data  = '0;
        errors    = 0;
        n_steps   = 0;
        n_loads   = 0;
        n_results = 0;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        rx_stall  = 0;
        for (int k = 0; k < 256; k++)
            sig_lut[k] = sigmoid_entry(k);
        for (int k = 0; k < 50; k++)
            weights[k] = '0;
        heading_q    = 0;
        speed_q      = 0;
        steps_q      = 0;
        turn_speed_q = 11520;
        max_speed_q  = 128;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset state and heading corner cases come first, before any weight exists.
        dir_rows.push_back(mk(2'd3, 0, 0, 0, 0, 1, 17'd0));
        dir_rows.push_back(mk(mst_pkg::KIND_HEADING, 0, 0, 0, -18'sd131072, 1, 17'd0));
        dir_rows.push_back(mk(mst_pkg::KIND_HEADING, 0, 0, 0, 18'sd131071, 1, 17'd38911));
        dir_rows.push_back(mk(mst_pkg::KIND_HEADING, 0, 0, 0, -18'sd1, 1, 17'd92159));
        dir_rows.push_back(mk(mst_pkg::KIND_HEADING, 0, 0, 0, 18'sd92160, 1, 17'd92160));
        dir_rows.push_back(mk(mst_pkg::KIND_HEADING, 0, 0, 0, 18'sd92161, 1, 17'd1));
        dir_rows.push_back(mk(mst_pkg::KIND_LOAD, 0, 0, 6'd63, 18'sd5, 1, 17'd1));
        dir_rows.push_back(mk(mst_pkg::KIND_LOAD, 0, 0, 6'd50, -18'sd7, 1, 17'd1));
        dir_rows.push_back(mk(mst_pkg::KIND_HEADING, 0, 0, 0, 18'sd0, 1, 17'd0));
        foreach (dir_rows[i])
        begin
            d = dir_rows[i];
            for (int j = 0; j < 9; j++)
                s[j] = d.sv;
            send_request(d.kind, s, d.idx, d.val, d.typed, d.exp_heading);
        end

        // Every weight slot is loaded before the first sensor step.
        for (int k = 0; k < 50; k++)
        begin
            for (int j = 0; j < 9; j++)
                s[j] = 16'($urandom());
            send_request(mst_pkg::KIND_LOAD, s, 6'(k), random_weight(), 0, 0);
        end

        dir_rows.delete();
        dir_rows.push_back(mk(mst_pkg::KIND_STEP, 0, 16'sh7FFF, 0, 0, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_STEP, 0, -16'sh8000, 0, 0, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_STEP, 0, 16'sd0, 0, 0, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_STEP, 1, 16'sh5555, 0, 0, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_LOAD, 0, 0, 6'd0, 18'sd131071, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_LOAD, 0, 0, 6'd49, -18'sd131072, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_LOAD, 0, 0, 6'd40, 18'sd40000, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_STEP, 1, 16'sh2AAA, 0, 0, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_STEP, 0, 16'sd256, 0, 0, 0, 0));
        dir_rows.push_back(mk(2'd3, 1, 16'sh7FFF, 6'd12, 18'sd3, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_HEADING, 0, 0, 0, 18'sd92000, 0, 0));
        dir_rows.push_back(mk(mst_pkg::KIND_STEP, 0, -16'sd256, 0, 0, 0, 0));
        foreach (dir_rows[i])
        begin
            d = dir_rows[i];
            for (int j = 0; j < 9; j++)
                s[j] = (d.alternate && j % 2 == 1) ? ~d.sv : d.sv;
            send_request(d.kind, s, d.idx, d.val, d.typed, d.exp_heading);
        end
        drain();

        // Random phases, each under its own turn and speed setting.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_config(mst_pkg::CFG_TURN_SPEED, 0);
                    write_config(mst_pkg::CFG_MAX_SPEED, 0);
                end
                1:
                begin
                    write_config(mst_pkg::CFG_TURN_SPEED, 23040);
                    write_config(mst_pkg::CFG_MAX_SPEED, 65535);
                end
                2:
                begin
                    write_config(mst_pkg::CFG_TURN_SPEED, 32767 & $urandom_range(0, 23040));
                    write_config(mst_pkg::CFG_MAX_SPEED, $urandom_range(0, 65535));
                end
                3:
                begin
                    write_config(mst_pkg::CFG_TURN_SPEED, 23040);
                    write_config(mst_pkg::CFG_MAX_SPEED, 1);
                end
                default:
                begin
                    write_config(mst_pkg::CFG_TURN_SPEED, 11520);
                    write_config(mst_pkg::CFG_MAX_SPEED, 128);
                end
            endcase
            tx_quiet = (ph == 1);
            rx_quiet = (ph == 3);
            repeat (176)
                random_request();
            drain();
        end

        $display("Covered %0d sensor steps and %0d load or other requests, %0d results checked,",
                 n_steps, n_loads, n_results);
        $display("over five turn and speed settings including both ends of each range.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: mlp_steering_controller.f
rtl/mst_pkg.sv
rtl/mst_ram.sv
rtl/mst_ctrl.sv
rtl/mst_dp.sv
rtl/mlp_steering_controller.sv
tb/sv/tb_mlp_steering_controller.sv
